>>> rtl/deq_pkg.sv
// Shared constants, opcodes and status codes of the double-ended queue unit.
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] count_type;

endpackage

>>> rtl/double_ended_queue_unit.sv
// Double-ended queue unit: ring buffer in a synchronous memory with head, tail and count.
// Pushes, failed requests and unused opcodes respond in the cycle after acceptance.
// Pops and peeks give it via the memory output register, then the response registers.
// One push per cycle unless responses stall; a pop or peek holds off the next request.
// Synchronous active-high reset empties the deque; memory contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [deq_pkg::OP_W-1:0]         req_opcode,
   input  logic [31:0]                      req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [deq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [31:0]                      rsp_read_value,
   output logic [deq_pkg::CNT_W-1:0]        rsp_count
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                          state_ff, state_in;
   deq_pkg::addr_type             head_ff, head_in;
   deq_pkg::addr_type             tail_ff, tail_in;
   deq_pkg::count_type            count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [deq_pkg::DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   deq_pkg::count_type            rsp_count_ff, rsp_count_in;

   logic [deq_pkg::DATA_W-1:0]    store_mem [deq_pkg::DEPTH];
   logic [deq_pkg::DATA_W-1:0]    mem_q_ff;

   logic                          accept;
   logic                          full;
   logic                          empty;
   deq_pkg::addr_type             head_prev, head_next, tail_prev, tail_next;
   logic                          mem_we, mem_re;
   deq_pkg::addr_type             mem_waddr, mem_raddr;

   assign req_stall = (state_ff == ST_READ) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign full = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   assign head_prev = (head_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : tail_ff - 1'b1;
   assign tail_next = (tail_ff == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = tail_ff;
      mem_raddr = head_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_READ: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_status_in = deq_pkg::STATUS_OK;
            rsp_data_in = mem_q_ff;
            rsp_count_in = count_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = deq_pkg::STATUS_OK;
               rsp_data_in = '0;
               rsp_count_in = count_ff;
               unique case (req_opcode)
                  deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = deq_pkg::STATUS_OVERFLOW;
                     end else begin
                        mem_we = 1'b1;
                        count_in = count_ff + 1'b1;
                        rsp_count_in = count_ff + 1'b1;
                        if (req_opcode == deq_pkg::OP_PUSH_FRONT) begin
                           mem_waddr = head_prev;
                           head_in = head_prev;
                        end else begin
                           mem_waddr = tail_ff;
                           tail_in = tail_next;
                        end
                     end
                  end
                  deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                  deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                     if (empty) begin
                        rsp_status_in = deq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        mem_re = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in = ST_READ;
                        if (req_opcode == deq_pkg::OP_POP_FRONT ||
                            req_opcode == deq_pkg::OP_PEEK_FRONT) begin
                           mem_raddr = head_ff;
                        end else begin
                           mem_raddr = tail_prev;
                        end
                        if (req_opcode == deq_pkg::OP_POP_FRONT) begin
                           head_in = head_next;
                           count_in = count_ff - 1'b1;
                        end else if (req_opcode == deq_pkg::OP_POP_BACK) begin
                           tail_in = tail_prev;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_value[deq_pkg::DATA_W-1:0];
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_value = 32'(rsp_data_ff);
   assign rsp_count = rsp_count_ff;

endmodule

>>> bench/tb_double_ended_queue_unit.sv
// Self-checking testbench of the double-ended queue unit with its scoreboard class.
`timescale 1ns / 1ps

typedef struct {
   logic [deq_pkg::STATUS_W-1:0] status;
   logic [31:0]                  read_value;
   deq_pkg::count_type           count;
} deque_result_type;

class deque_scoreboard;
   logic [31:0]        slots [deq_pkg::DEPTH];
   deq_pkg::addr_type  front_pos;
   deq_pkg::addr_type  back_pos;
   deq_pkg::count_type fill;
   deque_result_type   expected_q [$];
   int                 errors;

   function new();
      front_pos = '0;
      back_pos = '0;
      fill = '0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_request(logic [deq_pkg::OP_W-1:0] op, logic [31:0] value);
      deque_result_type  res;
      deq_pkg::addr_type pos;
      res.status = deq_pkg::STATUS_OK;
      res.read_value = '0;
      case (op)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
            if (fill == deq_pkg::DEPTH) begin
               res.status = deq_pkg::STATUS_OVERFLOW;
            end else if (op == deq_pkg::OP_PUSH_FRONT) begin
               front_pos = front_pos - 1'b1;
               slots[front_pos] = value;
               fill = fill + 1'b1;
            end else begin
               slots[back_pos] = value;
               back_pos = back_pos + 1'b1;
               fill = fill + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
         deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
            if (fill == 0) begin
               res.status = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               pos = (op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_PEEK_FRONT)
                     ? front_pos : back_pos - 1'b1;
               res.read_value = slots[pos];
               if (op == deq_pkg::OP_POP_FRONT) begin
                  front_pos = front_pos + 1'b1;
                  fill = fill - 1'b1;
               end else if (op == deq_pkg::OP_POP_BACK) begin
                  back_pos = pos;
                  fill = fill - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      res.count = fill;
      expected_q.push_back(res);
   endfunction

   function void check_response(logic [deq_pkg::STATUS_W-1:0] status,
                                logic [31:0] read_value, deq_pkg::count_type count);
      deque_result_type exp_res;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected transaction, status %0d value %h count %0d",
                  $time, status, read_value, count);
         return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status) begin
         errors++;
         $display("%0t: status expected %0d, actual %0d", $time, exp_res.status, status);
      end
      if (read_value !== exp_res.read_value) begin
         errors++;
         $display("%0t: read_value expected %h, actual %h",
                  $time, exp_res.read_value, read_value);
      end
      if (count !== exp_res.count) begin
         errors++;
         $display("%0t: count expected %0d, actual %0d", $time, exp_res.count, count);
      end
   endfunction
endclass

module tb_double_ended_queue_unit;

   localparam logic [deq_pkg::OP_W-1:0] OP_UNUSED_LOW  = 3'd6;
   localparam logic [deq_pkg::OP_W-1:0] OP_UNUSED_HIGH = 3'd7;
   localparam int RANDOM_ITEMS = 1525;
   localparam int LONG_HOLD = 80;
   localparam int CYCLE_LIMIT = 400000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [deq_pkg::OP_W-1:0]     req_opcode = '0;
   logic [31:0]                  req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [deq_pkg::STATUS_W-1:0] rsp_status;
   logic [31:0]                  rsp_read_value;
   deq_pkg::count_type           rsp_count;

   deque_scoreboard sb = new();
   int holds_asked = 0;
   int holds_served = 0;
   int cycle_count = 0;

   double_ended_queue_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_double_ended_queue_unit: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_opcode, req_value);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_status, rsp_read_value, rsp_count);
      end
   end

   initial begin : receiver_pacing
      int  n;
      int  k;
      logic level;
      @(posedge clock);
      forever begin
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            level = ($urandom_range(3) == 0);
            if ($urandom_range(19) == 0) begin
               n = level ? $urandom_range(10, 30) : $urandom_range(30, 40);
            end else begin
               n = level ? $urandom_range(1, 3) : $urandom_range(1, 12);
            end
            rsp_stall <= level;
            @(posedge clock);
            k = 1;
            while (k < n && holds_served == holds_asked) begin
               @(posedge clock);
               k++;
            end
         end
      end
   end

   task automatic send_item(input logic [deq_pkg::OP_W-1:0] op, input logic [31:0] value);
      req_opcode <= op;
      req_value <= value;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic int pick_gap(input bit busy);
      int r;
      r = $urandom_range(99);
      if (busy || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [deq_pkg::OP_W-1:0] pick_op(input int push_weight);
      int r;
      r = $urandom_range(99);
      if (r < 2) return $urandom_range(1) ? OP_UNUSED_LOW : OP_UNUSED_HIGH;
      if (r < 2 + push_weight) begin
         return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end
      case ($urandom_range(5))
         0, 4: return deq_pkg::OP_POP_FRONT;
         1, 5: return deq_pkg::OP_POP_BACK;
         2: return deq_pkg::OP_PEEK_FRONT;
         default: return deq_pkg::OP_PEEK_BACK;
      endcase
   endfunction

   initial begin : stimulus
      int          sent;
      int          seg;
      int          len;
      int          weight;
      bit          busy;
      logic [31:0] value;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
      idle_for(pick_gap(1'b0));
      send_item(deq_pkg::OP_PEEK_BACK, 32'hFFFF_FFFF);
      send_item(OP_UNUSED_HIGH, 32'hFFFF_FFFF);
      for (int i = 0; i < deq_pkg::DEPTH; i++) begin
         value = (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
         send_item((i % 2 == 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, value);
         idle_for(pick_gap(1'b0));
      end
      send_item(deq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_item(deq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
      send_item(OP_UNUSED_LOW, 32'h0000_0000);
      send_item(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000);
      send_item(deq_pkg::OP_PEEK_BACK, 32'h0000_0000);
      send_item(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
      send_item(deq_pkg::OP_POP_BACK, 32'h0000_0000);

      sent = 0;
      seg = 0;
      while (sent < RANDOM_ITEMS) begin
         len = $urandom_range(15, 60);
         case ($urandom_range(4))
            0: weight = 90;
            1: weight = 70;
            2: weight = 48;
            3: weight = 28;
            default: weight = 10;
         endcase
         busy = ($urandom_range(3) == 0);
         if (seg % 10 == 3) begin
            holds_asked++;
            busy = 1'b1;
            weight = 60;
            len = 80;
         end
         if (seg % 10 == 7) wait_drained();
         for (int i = 0; i < len; i++) begin
            send_item(pick_op(weight), pick_value());
            idle_for(pick_gap(busy));
            sent++;
         end
         seg++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_double_ended_queue_unit: done, clean");
      end else begin
         $display("tb_double_ended_queue_unit: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/deq_pkg.sv
rtl/double_ended_queue_unit.sv
bench/tb_double_ended_queue_unit.sv
